>>> design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared constants for the linear probe hash table
// Operation and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

   // parameter defaults
   localparam int LPHT_SLOTS     = 64;
   localparam int LPHT_KEY_BYTES = 8;

   // fixed field widths
   localparam int FUNC_W   = 2;
   localparam int KEYIN_W  = 64;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int ACT_W    = 7;

   // capacity register reset value
   localparam logic [ACT_W-1:0] ACT_RESET = 7'd64;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_GET    = 2'd1;
   localparam logic [FUNC_W-1:0] FN_ERASE  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_ARG   = 3'd4;

endpackage

`default_nettype wire

>>> design/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing key/value table, linear probing
// Insert, get and erase of keys of up to KEY_BYTES packed characters.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on req_valid/req_ready (req_func, req_key, req_value);
//   one response per request leaves on rsp_valid/rsp_ready (rsp_status,
//   rsp_found_value, rsp_slot), in request order.
//   csr_we writes csr_wdata into the capacity register (active slots); the
//   user must write it only while no request is outstanding: not enforced.
// Request flow
//   The front end takes a request and reduces its byte sum (HASH_W is the
//   width of the byte sum, 11 for eight-byte keys) modulo the capacity in
//   a one-bit-a-cycle remainder unit to give the start slot. The back end
//   then takes the request from the queue and probes up to capacity slots
//   through the single read port of the slot memory, then presents the
//   response. Early exits present the response without probing.
// Reset
//   Reset clears the entry count and sets capacity to 64, then the key
//   memory is swept empty slot by slot, during which req_ready is low.
// Stalls
//   While a response waits on rsp_ready the back end holds; a two-entry
//   queue lets the front end keep taking and classifying requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int SLOTS     = LPHT_SLOTS,
   parameter int KEY_BYTES = LPHT_KEY_BYTES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [ACT_W-1:0]     csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [KEYIN_W-1:0]   req_key,
   input  wire logic [VALUE_W-1:0]   req_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [VALUE_W-1:0]        rsp_found_value,
   output logic [SLOT_W-1:0]         rsp_slot
);

   localparam int KEY_W  = 8 * KEY_BYTES;
   localparam int CAP_W  = $clog2(SLOTS + 1);
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CMP_W  = (CAP_W > ACT_W) ? CAP_W : ACT_W;
   localparam int CMD_W  = FUNC_W + KEY_W + VALUE_W + IDX_W + 1;

   logic [ACT_W-1:0]  active_slots_ff;
   logic [CMP_W-1:0]  act_x;
   logic [CAP_W-1:0]  cap;
   logic              clr_busy;

   logic              fe_valid, fe_ready;
   logic [FUNC_W-1:0] fe_func;
   logic [KEY_W-1:0]  fe_key;
   logic [VALUE_W-1:0] fe_value;
   logic [IDX_W-1:0]  fe_start;
   logic              fe_bad;
   logic [CMD_W-1:0]  fe_data;

   logic              be_valid, be_ready;
   logic [CMD_W-1:0]  be_data;
   logic [FUNC_W-1:0] be_func;
   logic [KEY_W-1:0]  be_key;
   logic [VALUE_W-1:0] be_value;
   logic [IDX_W-1:0]  be_start;
   logic              be_bad;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_slots_ff <= ACT_RESET;
      end else if (csr_we) begin
         active_slots_ff <= csr_wdata;
      end
   end

   // effective capacity: zero acts as one, saturates at SLOTS
   always_comb begin
      act_x = CMP_W'(active_slots_ff);
      if (act_x == '0) begin
         cap = CAP_W'(1);
      end else if (act_x > CMP_W'(SLOTS)) begin
         cap = CAP_W'(SLOTS);
      end else begin
         cap = CAP_W'(act_x);
      end
   end

   // request intake and classification
   lpht_front #(
      .SLOTS     (SLOTS),
      .KEY_BYTES (KEY_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .clr_busy  (clr_busy),
      .cap       (cap),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_key   (req_key),
      .req_value (req_value),
      .cmd_valid (fe_valid),
      .cmd_ready (fe_ready),
      .cmd_func  (fe_func),
      .cmd_key   (fe_key),
      .cmd_value (fe_value),
      .cmd_start (fe_start),
      .cmd_bad   (fe_bad)
   );

   // command queue between front and back
   assign fe_data = {fe_func, fe_key, fe_value, fe_start, fe_bad};

   lpht_fifo #(
      .WIDTH (CMD_W)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fe_valid),
      .wr_ready (fe_ready),
      .wr_data  (fe_data),
      .rd_valid (be_valid),
      .rd_ready (be_ready),
      .rd_data  (be_data)
   );

   assign {be_func, be_key, be_value, be_start, be_bad} = be_data;

   // probing engine and slot store
   lpht_back #(
      .SLOTS     (SLOTS),
      .KEY_BYTES (KEY_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cap             (cap),
      .clr_busy        (clr_busy),
      .cmd_valid       (be_valid),
      .cmd_ready       (be_ready),
      .cmd_func        (be_func),
      .cmd_key         (be_key),
      .cmd_value       (be_value),
      .cmd_start       (be_start),
      .cmd_bad         (be_bad),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value),
      .rsp_slot        (rsp_slot)
   );

endmodule

`default_nettype wire

>>> design/lpht_fifo.sv
// ----------------------------------------------------------------------------
// lpht_fifo: two-entry command queue
// Decouples the classifying front end from the probing back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_ready,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   // handshake and pointer update
   always_comb begin
      wr_ready  = (fill_ff != 2'd2);
      rd_valid  = (fill_ff != 2'd0);
      rd_data   = entry_ff[rd_ptr_ff];
      push      = wr_valid && wr_ready;
      pop       = rd_valid && rd_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

>>> design/lpht_front.sv
// ----------------------------------------------------------------------------
// lpht_front: request intake and classification
// Normalises the key, sums its bytes, flags bad arguments and reduces the
// hash modulo the capacity one bit a cycle to give the start slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_front import lpht_pkg::*; #(
   parameter int SLOTS     = LPHT_SLOTS,
   parameter int KEY_BYTES = LPHT_KEY_BYTES
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clr_busy,
   input  wire logic [$clog2(SLOTS+1)-1:0]   cap,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [FUNC_W-1:0]            req_func,
   input  wire logic [KEYIN_W-1:0]           req_key,
   input  wire logic [VALUE_W-1:0]           req_value,
   output logic                              cmd_valid,
   input  wire logic                         cmd_ready,
   output logic [FUNC_W-1:0]                 cmd_func,
   output logic [8*KEY_BYTES-1:0]            cmd_key,
   output logic [VALUE_W-1:0]                cmd_value,
   output logic [$clog2(SLOTS)-1:0]          cmd_start,
   output logic                              cmd_bad
);

   localparam int KEY_W  = 8 * KEY_BYTES;
   localparam int CAP_W  = $clog2(SLOTS + 1);
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int HASH_W = $clog2(255 * KEY_BYTES + 1);
   localparam int REM_W  = CAP_W + 1;
   localparam int BIT_W  = $clog2(HASH_W);

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_type;

   front_state_type     state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                bad_ff, bad_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [CAP_W-1:0]    rem_ff, rem_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [KEY_W-1:0]    key_norm;
   logic [HASH_W-1:0]   hash_sum;
   logic                alive;
   logic [REM_W-1:0]    trial;

   // key normalisation and byte sum up to the first zero byte
   always_comb begin
      key_norm = '0;
      hash_sum = '0;
      alive    = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         alive = alive && (req_key[8*i +: 8] != 8'd0);
         if (alive) begin
            key_norm[8*i +: 8] = req_key[8*i +: 8];
            hash_sum           = hash_sum + HASH_W'(req_key[8*i +: 8]);
         end
      end
   end

   // one restoring remainder step
   always_comb begin
      trial = {rem_ff, hash_ff[HASH_W-1]};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      key_in   = key_ff;
      value_in = value_ff;
      bad_in   = bad_ff;
      hash_in  = hash_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && !clr_busy) begin
               func_in  = req_func;
               key_in   = key_norm;
               value_in = req_value;
               bad_in   = (key_norm == '0)
                          || (req_func != FN_INSERT && req_func != FN_GET
                              && req_func != FN_ERASE)
                          || (req_func == FN_INSERT && req_value == '0);
               hash_in  = hash_sum;
               rem_in   = '0;
               bit_in   = BIT_W'(HASH_W - 1);
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            rem_in  = (trial >= REM_W'(cap)) ? CAP_W'(trial - REM_W'(cap))
                                             : CAP_W'(trial);
            hash_in = hash_ff << 1;
            bit_in  = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (cmd_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // state and registered request fields
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff  <= func_in;
      key_ff   <= key_in;
      value_ff <= value_in;
      bad_ff   <= bad_in;
      hash_ff  <= hash_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == F_IDLE) && !clr_busy;
      cmd_valid = (state_ff == F_PUSH);
      cmd_func  = func_ff;
      cmd_key   = key_ff;
      cmd_value = value_ff;
      cmd_start = IDX_W'(rem_ff);
      cmd_bad   = bad_ff;
   end

endmodule

`default_nettype wire

>>> design/lpht_back.sv
// ----------------------------------------------------------------------------
// lpht_back: probing engine and slot store
// Holds the key and value memories and the entry count, clears the key
// memory after reset, probes one slot a cycle and registers the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_back import lpht_pkg::*; #(
   parameter int SLOTS     = LPHT_SLOTS,
   parameter int KEY_BYTES = LPHT_KEY_BYTES
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [$clog2(SLOTS+1)-1:0]   cap,
   output logic                              clr_busy,
   input  wire logic                         cmd_valid,
   output logic                              cmd_ready,
   input  wire logic [FUNC_W-1:0]            cmd_func,
   input  wire logic [8*KEY_BYTES-1:0]       cmd_key,
   input  wire logic [VALUE_W-1:0]           cmd_value,
   input  wire logic [$clog2(SLOTS)-1:0]     cmd_start,
   input  wire logic                         cmd_bad,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [STATUS_W-1:0]               rsp_status,
   output logic [VALUE_W-1:0]                rsp_found_value,
   output logic [SLOT_W-1:0]                 rsp_slot
);

   localparam int KEY_W   = 8 * KEY_BYTES;
   localparam int CAP_W   = $clog2(SLOTS + 1);
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SLOTX_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_OUT} back_state_type;

   logic [KEY_W-1:0]    key_mem [SLOTS];
   logic [VALUE_W-1:0]  val_mem [SLOTS];

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [CAP_W-1:0]    count_ff, count_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [IDX_W-1:0]    iss_addr_ff, iss_addr_in;
   logic [CAP_W-1:0]    iss_cnt_ff, iss_cnt_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                rd_last_ff, rd_last_in;
   logic [IDX_W-1:0]    rd_pos_ff, rd_pos_in;
   logic [KEY_W-1:0]    key_rd_ff;
   logic [VALUE_W-1:0]  val_rd_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  found_ff, found_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   logic                mem_we;
   logic                val_we;
   logic [IDX_W-1:0]    mem_wa;
   logic [KEY_W-1:0]    mem_wkey;
   logic                hit, empty;
   logic [SLOTX_W-1:0]  pos_x;

   // compare of the slot read back against the search key
   always_comb begin
      hit   = (key_rd_ff == key_ff);
      empty = (key_rd_ff == '0);
      pos_x = SLOTX_W'(rd_pos_ff);
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      count_in    = count_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      iss_addr_in = iss_addr_ff;
      iss_cnt_in  = iss_cnt_ff;
      rd_vld_in   = 1'b0;
      rd_last_in  = rd_last_ff;
      rd_pos_in   = rd_pos_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      mem_we      = 1'b0;
      val_we      = 1'b0;
      mem_wa      = rd_pos_ff;
      mem_wkey    = '0;
      cmd_ready   = 1'b0;
      case (state_ff)
         // sweep the key memory to empty after reset
         B_CLEAR: begin
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == IDX_W'(SLOTS - 1)) begin
               state_in = B_IDLE;
            end
         end
         // take the next request from the queue and settle early exits
         B_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               func_in     = cmd_func;
               key_in      = cmd_key;
               value_in    = cmd_value;
               iss_addr_in = cmd_start;
               iss_cnt_in  = '0;
               found_in    = '0;
               slot_in     = '0;
               if (cmd_bad) begin
                  status_in = ST_BAD_ARG;
                  state_in  = B_OUT;
               end else begin
                  case (cmd_func)
                     FN_INSERT: begin
                        if (count_ff >= cap) begin
                           status_in = ST_FULL;
                           state_in  = B_OUT;
                        end else begin
                           state_in = B_PROBE;
                        end
                     end
                     FN_GET, FN_ERASE: begin
                        if (count_ff == '0) begin
                           status_in = ST_NOT_FOUND;
                           state_in  = B_OUT;
                        end else begin
                           state_in = B_PROBE;
                        end
                     end
                     default: begin
                        status_in = ST_BAD_ARG;
                        state_in  = B_OUT;
                     end
                  endcase
               end
            end
         end
         // issue one slot read a cycle, check the slot read the cycle before
         B_PROBE: begin
            if (iss_cnt_ff < cap) begin
               rd_vld_in   = 1'b1;
               rd_pos_in   = iss_addr_ff;
               rd_last_in  = (iss_cnt_ff == cap - CAP_W'(1));
               iss_cnt_in  = iss_cnt_ff + CAP_W'(1);
               iss_addr_in = ((CAP_W'(iss_addr_ff) + CAP_W'(1)) == cap)
                             ? '0 : iss_addr_ff + IDX_W'(1);
            end
            if (rd_vld_ff) begin
               case (func_ff)
                  FN_INSERT: begin
                     if (hit) begin
                        status_in = ST_DUPLICATE;
                        state_in  = B_OUT;
                     end else if (empty) begin
                        mem_we    = 1'b1;
                        val_we    = 1'b1;
                        mem_wkey  = key_ff;
                        count_in  = count_ff + CAP_W'(1);
                        status_in = ST_OK;
                        slot_in   = pos_x[SLOT_W-1:0];
                        state_in  = B_OUT;
                     end else if (rd_last_ff) begin
                        status_in = ST_FULL;
                        state_in  = B_OUT;
                     end
                  end
                  default: begin
                     if (hit) begin
                        if (func_ff == FN_ERASE) begin
                           mem_we   = 1'b1;
                           count_in = count_ff - CAP_W'(1);
                        end
                        status_in = ST_OK;
                        found_in  = val_rd_ff;
                        slot_in   = pos_x[SLOT_W-1:0];
                        state_in  = B_OUT;
                     end else if (rd_last_ff) begin
                        status_in = ST_NOT_FOUND;
                        state_in  = B_OUT;
                     end
                  end
               endcase
               if (state_in == B_OUT) begin
                  rd_vld_in = 1'b0;
               end
            end
         end
         // hold the response until it is taken
         B_OUT: begin
            if (rsp_ready) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // state and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_CLEAR;
         clr_addr_ff <= '0;
         count_ff    <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         count_ff    <= count_in;
         rd_vld_ff   <= rd_vld_in;
      end
      func_ff     <= func_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      iss_addr_ff <= iss_addr_in;
      iss_cnt_ff  <= iss_cnt_in;
      rd_last_ff  <= rd_last_in;
      rd_pos_ff   <= rd_pos_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      slot_ff     <= slot_in;
   end

   // key and value memories, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_wa] <= mem_wkey;
      end
      if (val_we) begin
         val_mem[mem_wa] <= value_ff;
      end
      key_rd_ff <= key_mem[iss_addr_ff];
      val_rd_ff <= val_mem[iss_addr_ff];
   end

   // outputs
   always_comb begin
      clr_busy        = (state_ff == B_CLEAR);
      rsp_valid       = (state_ff == B_OUT);
      rsp_status      = status_ff;
      rsp_found_value = found_ff;
      rsp_slot        = slot_ff;
   end

endmodule

`default_nettype wire
